@@ hdl/pwe_pkg.sv @@
// Shared types and constants for the price indicator window engine.
package pwe_pkg;

  // Valid flags of the four indicators of one tick
  typedef struct packed {
    logic max_v;
    logic min_v;
    logic tr_v;
    logic ma_v;
  } pwe_flags_t;

  // 20000.0 in unsigned Q16.8
  localparam int unsigned MIN_CAP   = 32'd5120000;
  localparam int unsigned MIN_CAP_W = $clog2(MIN_CAP + 1);

endpackage

@@ hdl/pwe_front.sv @@
// Front end: takes tick transfers, counts ticks and classifies indicator validity.
module pwe_front import pwe_pkg::*; #(
  parameter int MA_WINDOW   = 5,
  parameter int MIN_WINDOW  = 100,
  parameter int MAX_WINDOW  = 50,
  parameter int PRICE_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3*PRICE_WIDTH-1:0] in_data,
  output logic                     push,
  input  logic                     push_ready,
  output logic [PRICE_WIDTH-1:0]   hi,
  output logic [PRICE_WIDTH-1:0]   lo,
  output logic [PRICE_WIDTH-1:0]   cl,
  output pwe_flags_t               flags
);

  localparam int WIN_BIG  = (MIN_WINDOW > MAX_WINDOW) ? MIN_WINDOW : MAX_WINDOW;
  localparam int SEEN_CAP = (WIN_BIG > MA_WINDOW) ? WIN_BIG : MA_WINDOW;
  localparam int SW       = $clog2(SEEN_CAP + 1);

  logic [SW-1:0] seen;
  logic [SW-1:0] seen_next;

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  assign hi = in_data[PRICE_WIDTH-1:0];
  assign lo = in_data[2*PRICE_WIDTH-1:PRICE_WIDTH];
  assign cl = in_data[3*PRICE_WIDTH-1:2*PRICE_WIDTH];

  assign seen_next = (seen >= SW'(SEEN_CAP)) ? SW'(SEEN_CAP) : seen + 1'b1;

  always_comb begin
    flags.ma_v  = seen >= SW'(MA_WINDOW);
    flags.tr_v  = seen != '0;
    flags.min_v = seen_next >= SW'(MIN_WINDOW);
    flags.max_v = seen_next >= SW'(MAX_WINDOW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (push) begin
      seen <= seen_next;
    end
  end

endmodule

@@ hdl/pwe_queue.sv @@
// Two-entry queue between the front end and the window engine.
module pwe_queue #(
  parameter int W = 76
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   count;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign dout       = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/pwe_back.sv @@
// Back end: history memories, window scan, reciprocal-multiply average and result register.
module pwe_back import pwe_pkg::*; #(
  parameter int MA_WINDOW   = 5,
  parameter int MIN_WINDOW  = 100,
  parameter int MAX_WINDOW  = 50,
  parameter int PRICE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   pop,
  input  logic [PRICE_WIDTH-1:0] item_hi,
  input  logic [PRICE_WIDTH-1:0] item_lo,
  input  logic [PRICE_WIDTH-1:0] item_cl,
  input  pwe_flags_t             item_flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PRICE_WIDTH-1:0] moving_avg,
  output logic [PRICE_WIDTH-1:0] true_range_out,
  output logic [PRICE_WIDTH-1:0] window_min_low,
  output logic [PRICE_WIDTH-1:0] window_max_high,
  output pwe_flags_t             out_flags,
  output logic                   idle
);

  localparam int PW       = PRICE_WIDTH;
  localparam int SCAN_A   = (MIN_WINDOW > MAX_WINDOW) ? MIN_WINDOW : MAX_WINDOW;
  localparam int SCAN_LEN = (SCAN_A > MA_WINDOW) ? SCAN_A : MA_WINDOW;
  localparam int SUM_W    = PW + $clog2(MA_WINDOW + 1);
  localparam int CW       = $clog2(SCAN_LEN + 1);
  localparam int CAW      = (MA_WINDOW > 1) ? $clog2(MA_WINDOW) : 1;
  localparam int LAW      = (MIN_WINDOW > 1) ? $clog2(MIN_WINDOW) : 1;
  localparam int HAW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DSH      = $clog2(MA_WINDOW);
  localparam int RK       = SUM_W + DSH;
  localparam int PRW      = SUM_W + RK + 1;
  // ceil(2^RK / MA_WINDOW): exact floor division for any SUM_W-bit sum
  localparam logic [RK:0] RECIP = (RK + 1)'(
    (((RK + 2)'(1) << RK) + (RK + 2)'(MA_WINDOW - 1)) / (RK + 2)'(MA_WINDOW));
  localparam logic [PW-1:0]  MN_INIT = (PW >= MIN_CAP_W) ? PW'(MIN_CAP) : {PW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;

  logic [PW-1:0] close_mem [MA_WINDOW];
  logic [PW-1:0] low_mem   [MIN_WINDOW];
  logic [PW-1:0] high_mem  [MAX_WINDOW];
  logic [PW-1:0] close_q;
  logic [PW-1:0] low_q;
  logic [PW-1:0] high_q;

  logic [CAW-1:0] close_wr;
  logic [LAW-1:0] low_wr;
  logic [HAW-1:0] high_wr;

  logic [CW-1:0]  cnt;
  logic           rd_v;
  logic [CW-1:0]  rd_idx;

  logic [PW-1:0]  hi_r;
  logic [PW-1:0]  lo_r;
  logic [PW-1:0]  cl_r;
  pwe_flags_t     flg;
  logic [PW-1:0]  close_last;
  logic [PW-1:0]  tr;
  logic [PW-1:0]  mn;
  logic [PW-1:0]  mx;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] quo;
  logic [PRW-1:0]   prod;

  logic [PW-1:0]  d_hl;
  logic [PW-1:0]  d_hp;
  logic [PW-1:0]  d_pl;
  logic [PW-1:0]  tr_next;
  logic           load_out;
  logic           scan_last;

  assign idle     = state == ST_IDLE;
  assign pop      = (state == ST_IDLE) && item_valid;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);
  assign scan_last = rd_v && (rd_idx == CW'(SCAN_LEN - 1));

  // true range; a high below the low drops the high-low term
  always_comb begin
    d_hl = (hi_r >= lo_r) ? hi_r - lo_r : '0;
    d_hp = (hi_r >= close_last) ? hi_r - close_last : close_last - hi_r;
    d_pl = (close_last >= lo_r) ? close_last - lo_r : lo_r - close_last;
    tr_next = d_hl;
    if (d_hp > tr_next) begin
      tr_next = d_hp;
    end
    if (d_pl > tr_next) begin
      tr_next = d_pl;
    end
  end

  assign sum_next = (rd_v && rd_idx < CW'(MA_WINDOW)) ? sum + SUM_W'(close_q) : sum;

  assign prod = PRW'(quo) * PRW'(RECIP);

  always_ff @(posedge clk) begin
    if (pop) begin
      low_mem[low_wr]   <= item_lo;
      high_mem[high_wr] <= item_hi;
    end
    if (load_out) begin
      close_mem[close_wr] <= cl_r;
    end
    close_q <= close_mem[cnt[CAW-1:0]];
    low_q   <= low_mem[cnt[LAW-1:0]];
    high_q  <= high_mem[cnt[HAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      rd_v       <= 1'b0;
      close_wr   <= '0;
      low_wr     <= '0;
      high_wr    <= '0;
      close_last <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_v <= (state == ST_SCAN) && (cnt < CW'(SCAN_LEN));
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cnt     <= '0;
            low_wr  <= (low_wr == LAW'(MIN_WINDOW - 1)) ? '0 : low_wr + 1'b1;
            high_wr <= (high_wr == HAW'(MAX_WINDOW - 1)) ? '0 : high_wr + 1'b1;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            cnt   <= '0;
            state <= ST_DIV;
          end else if (cnt < CW'(SCAN_LEN)) begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            close_last <= cl_r;
            close_wr   <= (close_wr == CAW'(MA_WINDOW - 1)) ? '0 : close_wr + 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    case (state)
      ST_IDLE: begin
        hi_r <= item_hi;
        lo_r <= item_lo;
        cl_r <= item_cl;
        flg  <= item_flags;
        mn   <= MN_INIT;
        mx   <= '0;
        sum  <= '0;
      end
      ST_SCAN: begin
        tr  <= tr_next;
        sum <= sum_next;
        if (rd_v && rd_idx < CW'(MIN_WINDOW) && low_q < mn) begin
          mn <= low_q;
        end
        if (rd_v && rd_idx < CW'(MAX_WINDOW) && high_q > mx) begin
          mx <= high_q;
        end
        if (scan_last) begin
          quo <= sum_next;
        end
      end
      ST_DIV: begin
        quo <= prod[RK +: SUM_W];
      end
      ST_DONE: begin
        if (load_out) begin
          moving_avg      <= flg.ma_v  ? quo[PW-1:0] : '0;
          true_range_out  <= flg.tr_v  ? tr : '0;
          window_min_low  <= flg.min_v ? mn : '0;
          window_max_high <= flg.max_v ? mx : '0;
          out_flags       <= flg;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/price_indicator_window_engine.sv @@
// Each tick (high, low, close in unsigned Q16.8) yields one result: the truncated mean of
// the MA_WINDOW earlier closes, the true range against the previous close, the minimum low
// over the last MIN_WINDOW ticks capped at 20000.0 and the maximum high over the last
// MAX_WINDOW ticks, each with a valid flag; an indicator that is not valid reads as zero.
// Each tick is worked on by a one-entry-a-cycle scan of the history memories over
// max(MA_WINDOW, MIN_WINDOW, MAX_WINDOW) entries; the average then comes from a
// reciprocal multiply in its own state. A two-entry queue takes further ticks while one is
// worked on, and a finished result waits in the output register.
module price_indicator_window_engine import pwe_pkg::*; #(
  parameter int MA_WINDOW   = 5,
  parameter int MIN_WINDOW  = 100,
  parameter int MAX_WINDOW  = 50,
  parameter int PRICE_WIDTH = 24,
  localparam int IN_W       = ((3 * PRICE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((4 * PRICE_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // high_price, low_price, close_price
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // moving_avg, moving_avg_valid, true_range_out,
                                      // true_range_valid, window_min_low, window_min_valid,
                                      // window_max_high, window_max_valid
);

  localparam int PW  = PRICE_WIDTH;
  localparam int QW  = 3 * PW + $bits(pwe_flags_t);
  localparam int OFW = 4 * PW + 4;

  logic          push;
  logic          push_ready;
  logic [PW-1:0] f_hi;
  logic [PW-1:0] f_lo;
  logic [PW-1:0] f_cl;
  pwe_flags_t    f_flags;
  logic [QW-1:0] q_din;
  logic [QW-1:0] q_dout;
  logic          q_valid;
  logic          q_pop;
  logic          back_idle;

  logic [PW-1:0] moving_avg;
  logic [PW-1:0] true_range_out;
  logic [PW-1:0] window_min_low;
  logic [PW-1:0] window_max_high;
  pwe_flags_t    out_flags;
  logic [OFW-1:0] out_fields;

  pwe_front #(
    .MA_WINDOW  (MA_WINDOW),
    .MIN_WINDOW (MIN_WINDOW),
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_WIDTH(PRICE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata[3*PW-1:0]),
    .push      (push),
    .push_ready(push_ready),
    .hi        (f_hi),
    .lo        (f_lo),
    .cl        (f_cl),
    .flags     (f_flags)
  );

  assign q_din = {f_flags, f_cl, f_lo, f_hi};

  pwe_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .din       (q_din),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .dout      (q_dout)
  );

  pwe_back #(
    .MA_WINDOW  (MA_WINDOW),
    .MIN_WINDOW (MIN_WINDOW),
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_WIDTH(PRICE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (q_valid),
    .pop            (q_pop),
    .item_hi        (q_dout[PW-1:0]),
    .item_lo        (q_dout[2*PW-1:PW]),
    .item_cl        (q_dout[3*PW-1:2*PW]),
    .item_flags     (pwe_flags_t'(q_dout[QW-1:3*PW])),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .moving_avg     (moving_avg),
    .true_range_out (true_range_out),
    .window_min_low (window_min_low),
    .window_max_high(window_max_high),
    .out_flags      (out_flags),
    .idle           (back_idle)
  );

  assign out_fields = {out_flags.max_v, window_max_high, out_flags.min_v, window_min_low,
                       out_flags.tr_v, true_range_out, out_flags.ma_v, moving_avg};
  assign m_tdata = OUT_W'(out_fields);

  // a queued tick is always picked up by an idle engine
  assert property (@(posedge clk) disable iff (rst) q_valid && back_idle |=> !back_idle)
    else $error("queued tick not taken by idle engine");

  // an average needs earlier ticks, so it is never valid without a true range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_flags.tr_v |-> !out_flags.ma_v)
    else $error("moving average valid without true range");

  // a pop only happens from a non-empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

@@ verif/price_indicator_window_engine_tb.sv @@
// Testbench for the price indicator window engine: random and directed ticks, result checks.
module price_indicator_window_engine_tb;
  import pwe_pkg::*;

  localparam int PW      = 24;
  localparam int MA_W    = 5;
  localparam int MIN_W   = 100;
  localparam int MAX_W   = 50;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 104;
  localparam int MAX_PX  = 24'hFFFFFF;
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES = 150;

  typedef logic [PW-1:0] price_t;

  typedef struct {
    price_t     avg;
    price_t     range;
    price_t     min_low;
    price_t     max_high;
    pwe_flags_t flags;
  } indicators_t;

  class indicator_scoreboard;
    price_t      close_ring[MA_W];
    price_t      low_ring[MIN_W];
    price_t      high_ring[MAX_W];
    int          close_wr, low_wr, high_wr;
    price_t      last_close;
    int          ticks_seen;
    indicators_t pending_results[$];
    int          mismatches;
    int          results_checked;
    int          capped_mins;
    int          floored_maxes;

    function new();
      close_wr = 0;
      low_wr = 0;
      high_wr = 0;
      last_close = '0;
      ticks_seen = 0;
      mismatches = 0;
      results_checked = 0;
      capped_mins = 0;
      floored_maxes = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40)
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function void note_tick(input price_t hi, input price_t lo, input price_t cl);
      indicators_t r;
      longint      sum;
      int          best, t, seen_now;
      price_t      m;
      r.avg = '0;
      r.range = '0;
      r.min_low = '0;
      r.max_high = '0;
      r.flags = '0;
      if (ticks_seen >= MA_W) begin
        sum = 0;
        for (int i = 0; i < MA_W; i++) sum += close_ring[i];
        r.avg = price_t'(sum / MA_W);
        r.flags.ma_v = 1'b1;
      end
      close_ring[close_wr] = cl;
      close_wr = (close_wr + 1 >= MA_W) ? 0 : close_wr + 1;
      if (ticks_seen >= 1) begin
        best = int'(hi) - int'(lo);
        t = (hi >= last_close) ? int'(hi) - int'(last_close) : int'(last_close) - int'(hi);
        if (t > best) best = t;
        t = (last_close >= lo) ? int'(last_close) - int'(lo) : int'(lo) - int'(last_close);
        if (t > best) best = t;
        r.range = best[PW-1:0];
        r.flags.tr_v = 1'b1;
      end
      low_ring[low_wr] = lo;
      low_wr = (low_wr + 1 >= MIN_W) ? 0 : low_wr + 1;
      high_ring[high_wr] = hi;
      high_wr = (high_wr + 1 >= MAX_W) ? 0 : high_wr + 1;
      seen_now = (ticks_seen >= MIN_W) ? MIN_W : ticks_seen + 1;
      if (seen_now >= MIN_W) begin
        m = price_t'(MIN_CAP);
        for (int i = 0; i < MIN_W; i++)
          if (low_ring[i] < m) m = low_ring[i];
        r.min_low = m;
        r.flags.min_v = 1'b1;
        if (m == price_t'(MIN_CAP)) capped_mins++;
      end
      if (seen_now >= MAX_W) begin
        m = '0;
        for (int i = 0; i < MAX_W; i++)
          if (high_ring[i] > m) m = high_ring[i];
        r.max_high = m;
        r.flags.max_v = 1'b1;
        if (m == '0) floored_maxes++;
      end
      last_close = cl;
      ticks_seen = seen_now;
      pending_results.push_back(r);
    endfunction

    task check_result(input logic [OUT_W-1:0] data);
      indicators_t want, got;
      got.avg            = data[23:0];
      got.flags.ma_v     = data[24];
      got.range          = data[48:25];
      got.flags.tr_v     = data[49];
      got.min_low        = data[73:50];
      got.flags.min_v    = data[74];
      got.max_high       = data[98:75];
      got.flags.max_v    = data[99];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%h with no tick pending", data));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.avg !== want.avg)
          report_mismatch($sformatf("result %0d moving_avg got %h want %h",
                                    results_checked, got.avg, want.avg));
        if (got.flags.ma_v !== want.flags.ma_v)
          report_mismatch($sformatf("result %0d moving_avg_valid got %b want %b",
                                    results_checked, got.flags.ma_v, want.flags.ma_v));
        if (got.range !== want.range)
          report_mismatch($sformatf("result %0d true_range_out got %h want %h",
                                    results_checked, got.range, want.range));
        if (got.flags.tr_v !== want.flags.tr_v)
          report_mismatch($sformatf("result %0d true_range_valid got %b want %b",
                                    results_checked, got.flags.tr_v, want.flags.tr_v));
        if (got.min_low !== want.min_low)
          report_mismatch($sformatf("result %0d window_min_low got %h want %h",
                                    results_checked, got.min_low, want.min_low));
        if (got.flags.min_v !== want.flags.min_v)
          report_mismatch($sformatf("result %0d window_min_valid got %b want %b",
                                    results_checked, got.flags.min_v, want.flags.min_v));
        if (got.max_high !== want.max_high)
          report_mismatch($sformatf("result %0d window_max_high got %h want %h",
                                    results_checked, got.max_high, want.max_high));
        if (got.flags.max_v !== want.flags.max_v)
          report_mismatch($sformatf("result %0d window_max_valid got %b want %b",
                                    results_checked, got.flags.max_v, want.flags.max_v));
        if (data[OUT_W-1:100] !== '0)
          report_mismatch($sformatf("result %0d pad bits got %h", results_checked,
                                    data[OUT_W-1:100]));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  indicator_scoreboard sb;
  int   ticks_in = 0;
  logic no_idle = 1'b0;
  logic hold_out = 1'b0;
  int   walk_price;

  price_indicator_window_engine DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one tick transfer; entered and left on a falling edge
  task send_tick(input price_t hi, input price_t lo, input price_t cl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cl, lo, hi};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(hi, lo, cl);
    ticks_in++;
    @(negedge clk);
  endtask

  function automatic price_t clamp_px(input int v);
    if (v < 0) return '0;
    if (v > MAX_PX) return price_t'(MAX_PX);
    return price_t'(v);
  endfunction

  // random walk tick; now and then high and low come swapped
  task walk_tick();
    price_t hi, lo, cl, tmp;
    walk_price = int'(clamp_px(walk_price + $urandom_range(0, 4000) - 2000));
    hi = clamp_px(walk_price + $urandom_range(0, 3000));
    lo = clamp_px(walk_price - $urandom_range(0, 3000));
    cl = clamp_px(int'(lo) + $urandom_range(0, int'(hi) - int'(lo)));
    if ($urandom_range(0, 15) == 0) begin
      tmp = hi;
      hi = lo;
      lo = tmp;
    end
    send_tick(hi, lo, cl);
  endtask

  initial begin
    #5_000_000;
    $display("price_indicator_window_engine_tb failed");
    $finish;
  end

  // long output stall so the input queue fills and backs up
  initial begin
    wait (ticks_in >= 40);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
  end

  initial begin
    int gap;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      while (hold_out) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, high below low, cap boundary, full-scale average
    send_tick(24'h000000, 24'h000000, 24'h000000);
    send_tick(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    send_tick(24'h000000, 24'hFFFFFF, 24'h000000);
    for (int i = 0; i < 6; i++) send_tick(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_tick(24'h800000, 24'h7FFFFF, 24'h555555);
    send_tick(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    send_tick(24'h555555, 24'hAAAAAA, 24'h800000);
    send_tick(price_t'(MIN_CAP - 1), price_t'(MIN_CAP), price_t'(MIN_CAP + 1));
    send_tick(24'h123456, 24'h100000, 24'h111111);
    send_tick(24'h000001, 24'h000000, 24'h000001);

    walk_price = $urandom_range(200000, 4000000);
    for (int i = 0; i < 230; i++) walk_tick();

    // lows above the cap for more than a full window
    no_idle = 1'b1;
    walk_price = $urandom_range(7000000, 12000000);
    for (int i = 0; i < 120; i++) walk_tick();
    no_idle = 1'b0;

    for (int i = 0; i < 80; i++)
      send_tick(price_t'($urandom), price_t'($urandom), price_t'($urandom));

    // all-zero highs for more than a full window
    for (int i = 0; i < 60; i++)
      send_tick(24'h000000, price_t'($urandom_range(0, 255)), price_t'($urandom_range(0, 4095)));

    walk_price = $urandom_range(0, MAX_PX);
    for (int i = 0; i < 45; i++) walk_tick();

    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d ticks, checked %0d results (%0d capped window minimums,",
             ticks_in, sb.results_checked, sb.capped_mins);
    $display("%0d zero window maximums) through a %0d-cycle output stall.",
             sb.floored_maxes, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("price_indicator_window_engine_tb passed");
    end else begin
      $display("price_indicator_window_engine_tb failed");
    end
    $finish;
  end

endmodule
